// ===== src/quaternion_rotate_vector_defines.svh =====
// ---------------------------------------------------------------------------
// quaternion_rotate_vector_defines
// assertion macros used by the quaternion rotation rtl
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define QRV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrv assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define QRV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrv assertion failed");

`endif

// ===== src/qrv_pkg.sv =====
// ---------------------------------------------------------------------------
// qrv_pkg
// widths, constants and word types of the quaternion vector rotation
// ---------------------------------------------------------------------------
package qrv_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;

    localparam int PROD_W = 2 * COMPONENT_WIDTH;
    localparam int MAT_W  = 2 * COMPONENT_WIDTH + 2;
    localparam int ACC_W  = 3 * COMPONENT_WIDTH + 2;
    localparam int SHIFT  = 2 * FRACTION_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);

    localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MAX =
        {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
    localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MIN =
        {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] quat_w;
        logic signed [COMPONENT_WIDTH-1:0] quat_x;
        logic signed [COMPONENT_WIDTH-1:0] quat_y;
        logic signed [COMPONENT_WIDTH-1:0] quat_z;
        logic signed [COMPONENT_WIDTH-1:0] vec_x;
        logic signed [COMPONENT_WIDTH-1:0] vec_y;
        logic signed [COMPONENT_WIDTH-1:0] vec_z;
    } quat_word_t;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] rot_x;
        logic signed [COMPONENT_WIDTH-1:0] rot_y;
        logic signed [COMPONENT_WIDTH-1:0] rot_z;
        logic                              saturated;
    } rot_word_t;

endpackage

// ===== src/quaternion_rotate_vector.sv =====
// an accepted word passes the input, product, matrix, term, sum and output registers on its way to rot_data
// throughput: one word per cycle while rot_ready holds; six register stages, bubbles squeeze out on stall
// the stage at the deepest point is one 34 x 16 multiply per matrix entry
// reset: rst_n clears all stage valid bits at once, data registers are not reset
// ---------------------------------------------------------------------------
// quaternion_rotate_vector
// rotates a vector by a q2.14 quaternion, q * (0, v) * conj(q), computed as
// a rotation matrix times v, rounded to nearest and saturated
// ---------------------------------------------------------------------------
`include "quaternion_rotate_vector_defines.svh"

module quaternion_rotate_vector
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quat_valid,
    output logic                quat_ready,
    input  qrv_pkg::quat_word_t quat_data,
    output logic                rot_valid,
    input  logic                rot_ready,
    output qrv_pkg::rot_word_t  rot_data
);

    localparam int STAGES = 6;
    localparam int CW     = qrv_pkg::COMPONENT_WIDTH;
    localparam int PW     = qrv_pkg::PROD_W;
    localparam int MW     = qrv_pkg::MAT_W;
    localparam int AW     = qrv_pkg::ACC_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    // stage 0: input word
    qrv_pkg::quat_word_t in_reg;

    // stage 1: component products
    logic signed [PW-1:0] p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg, p_xy_reg;
    logic signed [PW-1:0] p_xz_reg, p_yz_reg, p_wx_reg, p_wy_reg, p_wz_reg;
    logic signed [CW-1:0] vec1_reg [3];

    // stage 2: rotation matrix, row major
    logic signed [MW-1:0] mat_reg  [9];
    logic signed [MW-1:0] mat_next [9];
    logic signed [CW-1:0] vec2_reg [3];

    // stage 3: matrix times vector terms
    logic signed [AW-1:0] term_reg [9];

    // stage 4: row sums with rounding offset
    logic signed [AW-1:0] sum_reg  [3];

    // stage 5: output word
    qrv_pkg::rot_word_t   rot_reg;
    qrv_pkg::rot_word_t   rot_next;
    logic [2:0]           clip;
    logic                 rot_extreme;

    // stall chain
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || rot_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? quat_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign quat_ready = adv[0];
    assign rot_valid  = vld_reg[STAGES-1];
    assign rot_data   = rot_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            in_reg <= quat_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            p_ww_reg    <= in_reg.quat_w * in_reg.quat_w;
            p_xx_reg    <= in_reg.quat_x * in_reg.quat_x;
            p_yy_reg    <= in_reg.quat_y * in_reg.quat_y;
            p_zz_reg    <= in_reg.quat_z * in_reg.quat_z;
            p_xy_reg    <= in_reg.quat_x * in_reg.quat_y;
            p_xz_reg    <= in_reg.quat_x * in_reg.quat_z;
            p_yz_reg    <= in_reg.quat_y * in_reg.quat_z;
            p_wx_reg    <= in_reg.quat_w * in_reg.quat_x;
            p_wy_reg    <= in_reg.quat_w * in_reg.quat_y;
            p_wz_reg    <= in_reg.quat_w * in_reg.quat_z;
            vec1_reg[0] <= in_reg.vec_x;
            vec1_reg[1] <= in_reg.vec_y;
            vec1_reg[2] <= in_reg.vec_z;
        end
    end

    always_comb
    begin
        mat_next[0] = MW'(p_ww_reg) + MW'(p_xx_reg) - MW'(p_yy_reg) - MW'(p_zz_reg);
        mat_next[1] = (MW'(p_xy_reg) - MW'(p_wz_reg)) <<< 1;
        mat_next[2] = (MW'(p_xz_reg) + MW'(p_wy_reg)) <<< 1;
        mat_next[3] = (MW'(p_xy_reg) + MW'(p_wz_reg)) <<< 1;
        mat_next[4] = MW'(p_ww_reg) - MW'(p_xx_reg) + MW'(p_yy_reg) - MW'(p_zz_reg);
        mat_next[5] = (MW'(p_yz_reg) - MW'(p_wx_reg)) <<< 1;
        mat_next[6] = (MW'(p_xz_reg) - MW'(p_wy_reg)) <<< 1;
        mat_next[7] = (MW'(p_yz_reg) + MW'(p_wx_reg)) <<< 1;
        mat_next[8] = MW'(p_ww_reg) - MW'(p_xx_reg) - MW'(p_yy_reg) + MW'(p_zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= mat_next[i];
            end
            for (int c = 0; c < 3; c++)
            begin
                vec2_reg[c] <= vec1_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 9; i++)
            begin
                term_reg[i] <= mat_reg[i] * vec2_reg[i % 3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= term_reg[3*r] + term_reg[3*r+1] + term_reg[3*r+2]
                              + qrv_pkg::ROUND_HALF;
            end
        end
    end

    qrv_round_sat u_round_x
    (
        .acc   (sum_reg[0]),
        .value (rot_next.rot_x),
        .clip  (clip[0])
    );

    qrv_round_sat u_round_y
    (
        .acc   (sum_reg[1]),
        .value (rot_next.rot_y),
        .clip  (clip[1])
    );

    qrv_round_sat u_round_z
    (
        .acc   (sum_reg[2]),
        .value (rot_next.rot_z),
        .clip  (clip[2])
    );

    assign rot_next.saturated = |clip;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot_extreme = (rot_data.rot_x == qrv_pkg::COMP_MAX)
                      || (rot_data.rot_x == qrv_pkg::COMP_MIN)
                      || (rot_data.rot_y == qrv_pkg::COMP_MAX)
                      || (rot_data.rot_y == qrv_pkg::COMP_MIN)
                      || (rot_data.rot_z == qrv_pkg::COMP_MAX)
                      || (rot_data.rot_z == qrv_pkg::COMP_MIN);

    `QRV_ASSERT_NEXT(a_accept_fills_input, quat_valid && quat_ready, vld_reg[0])
    `QRV_ASSERT_SAME(a_backpressure_only_when_full, !quat_ready, vld_reg[0])
    `QRV_ASSERT_NEXT(a_last_stage_moves_out, vld_reg[STAGES-2] && adv[STAGES-1], rot_valid)
    `QRV_ASSERT_SAME(a_saturated_means_extreme, rot_valid && rot_data.saturated, rot_extreme)

endmodule

// ===== src/qrv_round_sat.sv =====
// ---------------------------------------------------------------------------
// qrv_round_sat
// scales a rounded accumulator down by twice the fraction bits and clips it
// ---------------------------------------------------------------------------
module qrv_round_sat
(
    input  logic signed [qrv_pkg::ACC_W-1:0]           acc,
    output logic signed [qrv_pkg::COMPONENT_WIDTH-1:0] value,
    output logic                                       clip
);

    localparam int TOP_LO = qrv_pkg::SHIFT + qrv_pkg::COMPONENT_WIDTH - 1;

    logic [qrv_pkg::ACC_W-1-TOP_LO:0] top_bits;

    assign top_bits = acc[qrv_pkg::ACC_W-1:TOP_LO];
    assign clip     = !((&top_bits) || !(|top_bits));

    always_comb
    begin
        if (!clip)
        begin
            value = acc[TOP_LO:qrv_pkg::SHIFT];
        end
        else if (acc[qrv_pkg::ACC_W-1])
        begin
            value = qrv_pkg::COMP_MIN;
        end
        else
        begin
            value = qrv_pkg::COMP_MAX;
        end
    end

endmodule
